### hdl/nic_pkg.sv
// Shared types and constants of the negative id cache.
package nic_pkg;

    localparam int ID_W = 64;
    localparam int OP_W = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE   = 2'd1;
    localparam logic [OP_W-1:0] OP_CONTAINS = 2'd2;

    // Default geometry.
    localparam int DEF_SETS = 16;
    localparam int DEF_WAYS = 4;

    // The set index of a non power of two set count is found eight id bits per cycle.
    localparam int DIGIT_W   = 8;
    localparam int MOD_STEPS = ID_W / DIGIT_W;
    localparam int CNT_W     = $clog2(MOD_STEPS + 1);

    // Depth of the request queue between the front and the back.
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic [ID_W-1:0] id;
    } nic_cmd_t;

endpackage

### hdl/nic_if.sv
// Request and response channel interfaces of the negative id cache.
interface nic_req_if
    import nic_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [OP_W-1:0] operation;
    logic [ID_W-1:0] id;

    modport source (output valid, output operation, output id, input ready);
    modport sink (input valid, input operation, input id, output ready);
endinterface

interface nic_rsp_if
    import nic_pkg::*;
();
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, output found, input ready);
    modport sink (input valid, input found, output ready);
endinterface

### hdl/nic_ram.sv
// Generic single write port memory with a registered read port.
module nic_ram
    import nic_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/nic_front.sv
// Front part: accepts request items and works out their set index.
module nic_front
    import nic_pkg::*;
#(
    parameter int SETS = DEF_SETS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    nic_req_if.sink                                 req,
    input  logic                                    init_done,
    output logic                                    push_valid,
    input  logic                                    push_ready,
    output nic_cmd_t                                push_cmd,
    output logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] push_set
);

    localparam int   SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam bit   POW2  = ((SETS & (SETS - 1)) == 0);
    localparam logic [CNT_W-1:0] STEPS = POW2 ? '0 : CNT_W'(MOD_STEPS);
    localparam logic [SET_W:0]   SETS_X = (SET_W + 1)'(SETS);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    nic_cmd_t         cmd_reg, cmd_next;
    logic [ID_W-1:0]  shift_reg, shift_next;
    logic [SET_W-1:0] rem_reg, rem_next;
    logic [SET_W-1:0] rem_step;
    logic             accept;

    assign req.ready = !busy_reg && init_done;
    assign accept    = req.valid && req.ready;

    // Remainder update over the top eight bits, most significant bit first.
    always_comb
    begin
        logic [SET_W:0] tmp;
        tmp      = '0;
        rem_step = rem_reg;
        for (int k = 0; k < DIGIT_W; k++)
        begin
            tmp = {rem_step, shift_reg[ID_W-1-k]};
            if (tmp >= SETS_X)
            begin
                tmp = tmp - SETS_X;
            end
            rem_step = tmp[SET_W-1:0];
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        cmd_next   = cmd_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        if (accept)
        begin
            busy_next          = 1'b1;
            cnt_next           = STEPS;
            cmd_next.operation = req.operation;
            cmd_next.id        = req.id;
            shift_next         = req.id;
            rem_next           = '0;
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            cnt_next   = cnt_reg - 1'b1;
            shift_next = shift_reg << DIGIT_W;
            rem_next   = rem_step;
        end
        else if (busy_reg && push_ready)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign push_valid = busy_reg && (cnt_reg == '0);
    assign push_cmd   = cmd_reg;
    assign push_set   = (SETS == 1) ? '0 : (POW2 ? cmd_reg.id[SET_W-1:0] : rem_reg);

endmodule

### hdl/nic_queue.sv
// Two entry request queue between the front and the back.
module nic_queue
    import nic_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_QW = $clog2(QDEPTH + 1);

    logic [WIDTH-1:0]  slot_reg [QDEPTH];
    logic [PTR_W-1:0]  wr_reg, rd_reg;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != CNT_QW'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = slot_reg[rd_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

endmodule

### hdl/nic_back.sv
// Back part: clears the store after reset, then reads, updates and writes back one set per item.
module nic_back
    import nic_pkg::*;
#(
    parameter int SETS = DEF_SETS,
    parameter int WAYS = DEF_WAYS
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    pop_valid,
    output logic                                    pop_ready,
    input  nic_cmd_t                                pop_cmd,
    input  logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] pop_set,
    output logic                                    init_done,
    nic_rsp_if.source                               rsp
);

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W = WAYS * ID_W + WAY_W;
    localparam logic [SET_W-1:0] LAST_SET = SET_W'(SETS - 1);
    localparam logic [WAY_W-1:0] LAST_WAY = WAY_W'(WAYS - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [SET_W-1:0] clr_reg, clr_next;
    nic_cmd_t         cmd_reg;
    logic [SET_W-1:0] set_reg;
    logic             out_valid_reg, out_valid_next;
    logic             found_reg, found_next;

    logic             ram_we, ram_re;
    logic [SET_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata, ram_rdata, row_new;
    logic             hit, done;
    logic             take;

    nic_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (pop_set),
        .rdata (ram_rdata)
    );

    // Set update: all ways compared in parallel, pointer kept above the ways.
    always_comb
    begin
        logic [WAY_W-1:0] ptr;
        logic [ID_W-1:0]  way_val;
        logic             match;
        ptr     = ram_rdata[ROW_W-1 -: WAY_W];
        row_new = ram_rdata;
        hit     = 1'b0;
        for (int w = 0; w < WAYS; w++)
        begin
            way_val = ram_rdata[w*ID_W +: ID_W];
            match   = (way_val == cmd_reg.id);
            unique case (cmd_reg.operation)
                OP_INSERT:
                begin
                    if (WAY_W'(w) == ptr)
                    begin
                        row_new[w*ID_W +: ID_W] = cmd_reg.id;
                    end
                end
                OP_REMOVE:
                begin
                    if (match)
                    begin
                        row_new[w*ID_W +: ID_W] = '0;
                    end
                end
                OP_CONTAINS:
                begin
                    hit = hit | match;
                end
                default:
                begin
                end
            endcase
        end
        if (cmd_reg.operation == OP_INSERT)
        begin
            row_new[ROW_W-1 -: WAY_W] = (ptr == LAST_WAY) ? '0 : ptr + 1'b1;
        end
    end

    assign done      = (state_reg == ST_EXEC) && (!out_valid_reg || rsp.ready);
    assign pop_ready = (state_reg == ST_IDLE);
    assign take      = pop_valid && pop_ready;
    assign ram_re    = take;
    assign ram_we    = (state_reg == ST_CLEAR) || done;
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_reg : set_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? '0 : row_new;
    assign init_done = (state_reg != ST_CLEAR);

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        found_next     = found_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST_SET)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (done)
                begin
                    out_valid_next = 1'b1;
                    found_next     = hit;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        if (take)
        begin
            cmd_reg <= pop_cmd;
            set_reg <= pop_set;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.found = found_reg;

endmodule

### hdl/negative_id_cache.sv
// Top level of the negative id cache: a set-associative store of ids known not to exist.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+------------------------------------
//  req     | in  | valid, ready | operation (2 bits), id (64 bits)
//  rsp     | out | valid, ready | found (1 bit), one item per request
//
// After reset the store is cleared one set per cycle, with req.ready low.
// The front holds one item at a time. Its set index is the low id bits when SETS is a
// power of two, else it comes from an eight-bit-per-cycle remainder unit. The item
// then moves to the queue. The back does a read-modify-write of a store with a
// registered read: it reads the set row, then updates it and loads the rsp register.
// A stalled rsp holds the back in its write-back cycle; the queue fills, then the front.
module negative_id_cache
    import nic_pkg::*;
#(
    parameter int SETS = DEF_SETS,
    parameter int WAYS = DEF_WAYS
) (
    input  logic      clk,
    input  logic      rst_n,
    nic_req_if.sink   req,
    nic_rsp_if.source rsp
);

    localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int QW    = $bits(nic_cmd_t) + SET_W;

    // Front to queue.
    logic             f_valid, f_ready;
    nic_cmd_t         f_cmd;
    logic [SET_W-1:0] f_set;

    // Queue to back.
    logic             b_valid, b_ready;
    nic_cmd_t         b_cmd;
    logic [SET_W-1:0] b_set;
    logic [QW-1:0]    q_out;

    // Low while the clearing pass runs.
    logic             init_done;

    nic_front #(
        .SETS (SETS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .init_done  (init_done),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_cmd   (f_cmd),
        .push_set   (f_set)
    );

    nic_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  ({f_cmd, f_set}),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_data   (q_out)
    );

    assign b_cmd = q_out[QW-1 -: $bits(nic_cmd_t)];
    assign b_set = q_out[SET_W-1:0];

    nic_back #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (b_valid),
        .pop_ready (b_ready),
        .pop_cmd   (b_cmd),
        .pop_set   (b_set),
        .init_done (init_done),
        .rsp       (rsp)
    );

endmodule
